[hw/rtl/utf8_glyph_index_lookup_core_defines.svh]
// assertion macros shared by the glyph lookup rtl
// depends on a clk and an active-low rst_n in the including module
`ifndef UTF8_GLYPH_INDEX_LOOKUP_CORE_DEFINES_SVH
`define UTF8_GLYPH_INDEX_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UGIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UGIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ugil_pkg.sv]
// shared types and constants of the utf-8 glyph index lookup core
// no dependencies
package ugil_pkg;

  // input item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // glyph_count value after reset
  localparam logic [8:0] GC_RESET = 9'd2;

  // continuation payload mask and lead marker
  localparam logic [7:0] CONT_MASK = 8'h3F;
  localparam logic [7:0] LEAD_BIT  = 8'h80;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [31:0] entry_codepoint;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  glyph_index;
    logic        found;
    logic [31:0] codepoint_out;
  } out_item_t;

  // decoder to search handoff
  typedef struct packed {
    logic        done;
    logic [31:0] cp;
  } dec_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_FIN
  } srch_state_t;

endpackage

[hw/rtl/ugil_decoder.sv]
// utf-8 byte decoder: accumulates one codepoint over a multi-byte sequence
// depends on ugil_pkg
module ugil_decoder
  import ugil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] text_byte,
  output dec_res_t   res
);

  logic [31:0] partial_r, partial_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [3:0]  lead_len;
  logic [31:0] cp_lead;
  logic [31:0] cp_cont;
  logic        done_c;
  logic [31:0] cp_c;

  // count of leading ones in a lead byte, 0 to 8
  function automatic logic [3:0] count_lead(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // lead and continuation values
  always_comb begin
    lead_len = count_lead(text_byte);
    cp_lead  = lead_len[3] ? 32'd0 : 32'(text_byte & (8'hFF >> lead_len[2:0]));
    cp_cont  = {partial_r[25:0], text_byte[5:0] & CONT_MASK[5:0]};
  end

  // sequence tracking
  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    done_c      = 1'b0;
    cp_c        = cp_lead;
    if (left_r == 3'd0) begin
      if (lead_len > 4'd1) begin
        partial_nxt = cp_lead;
        left_nxt    = 3'(lead_len - 4'd1);
      end else begin
        // ascii byte or stray continuation completes at once
        done_c = 1'b1;
      end
    end else begin
      cp_c     = cp_cont;
      left_nxt = left_r - 3'd1;
      if (left_r == 3'd1) begin
        done_c      = 1'b1;
        partial_nxt = 32'd0;
      end else begin
        partial_nxt = cp_cont;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 32'd0;
      left_r    <= 3'd0;
    end else if (byte_en) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
    end
  end

  assign res.done = byte_en & done_c;
  assign res.cp   = cp_c;

endmodule

[hw/rtl/ugil_search.sv]
// codepoint table memory and binary search sequencer with output register
// depends on ugil_pkg and utf8_glyph_index_lookup_core_defines.svh
module ugil_search
  import ugil_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [8:0]  glyph_count,
  input  logic        ld_en,
  input  logic [7:0]  ld_idx,
  input  logic [31:0] ld_cp,
  input  logic        start,
  input  logic [31:0] start_cp,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

`include "utf8_glyph_index_lookup_core_defines.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = AW + 1;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  srch_state_t state_r, state_nxt;
  logic [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [31:0]   cp_r, cp_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [SW-1:0] n_c;
  logic          wr_ok;
  logic          step_eq, step_lt, step_done;
  logic [SW-1:0] lo_up, hi_dn;
  logic          out_load;

  // table entries in use, clamped to the memory depth
  always_comb begin
    if (32'(glyph_count) >= TABLE_DEPTH) begin
      n_c = SW'(TABLE_DEPTH);
    end else begin
      n_c = SW'(glyph_count);
    end
  end

  function automatic logic [SW-1:0] midpoint(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SW:1];
  endfunction

  // table memory, loads only while idle so no read can overlap a write
  assign wr_ok   = (32'(ld_idx) < TABLE_DEPTH);
  assign rd_addr = AW'(mid_nxt);

  always_ff @(posedge clk) begin
    if (ld_en && wr_ok) begin
      mem[AW'(ld_idx)] <= ld_cp;
    end
    rd_data_r <= mem[rd_addr];
  end

  // one compare per cycle against the entry read at mid_r
  always_comb begin
    step_eq   = (rd_data_r == cp_r);
    step_lt   = (rd_data_r < cp_r);
    lo_up     = mid_r + SW'(1);
    hi_dn     = mid_r - SW'(1);
    if (step_eq) begin
      step_done = 1'b1;
    end else if (step_lt) begin
      step_done = (lo_up > hi_r);
    end else begin
      step_done = (mid_r == '0) || (lo_r > hi_dn);
    end
  end

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (n_c == '0) ? ST_FIN : ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (step_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SRCH: busy = 1'b1;
      ST_FIN:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // search bounds and result
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    cp_nxt    = cp_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    if (state_r == ST_IDLE && start) begin
      cp_nxt    = start_cp;
      idx_nxt   = '0;
      found_nxt = 1'b0;
      lo_nxt    = '0;
      hi_nxt    = n_c - SW'(1);
      mid_nxt   = midpoint('0, n_c - SW'(1));
    end else if (state_r == ST_SRCH) begin
      if (step_eq) begin
        idx_nxt   = AW'(mid_r);
        found_nxt = 1'b1;
      end else if (step_lt) begin
        lo_nxt  = lo_up;
        mid_nxt = midpoint(lo_up, hi_r);
      end else if (mid_r != '0) begin
        hi_nxt  = hi_dn;
        mid_nxt = midpoint(lo_r, hi_dn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lo_r    <= '0;
      hi_r    <= '0;
      mid_r   <= '0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      mid_r   <= mid_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r <= cp_nxt;
  end

  // output register, holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.glyph_index   <= 8'(idx_r);
      out_data_r.found         <= found_r;
      out_data_r.codepoint_out <= cp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `UGIL_ASSERT_NOW(a_bounds_order, state_r == ST_SRCH, lo_r <= hi_r, "search bounds crossed")
  `UGIL_ASSERT_NOW(a_mid_in_range, state_r == ST_SRCH, (mid_r >= lo_r) && (mid_r <= hi_r),
                   "probe outside search bounds")
  `UGIL_ASSERT_NOW(a_load_idle, ld_en, state_r == ST_IDLE, "table load during search")
  `UGIL_ASSERT_NOW(a_miss_zero, out_load && !found_r, idx_r == '0, "miss with nonzero index")
  `UGIL_ASSERT_NEXT(a_start_busy, state_r == ST_IDLE && start, busy, "start did not engage search")

endmodule

[hw/rtl/utf8_glyph_index_lookup_core.sv]
// utf-8 glyph index lookup core: table loads, utf-8 decode, binary search
// depends on ugil_pkg, ugil_decoder and ugil_search
//
// usage
//   in_*  : one transaction per item. opcode OP_LOAD writes entry_codepoint to
//           table slot entry_index (slots at or past TABLE_DEPTH are dropped);
//           opcode OP_TEXT feeds text_byte to the utf-8 decoder.
//   out_* : one transaction per completed codepoint: glyph_index, found and
//           the codepoint itself. loads and partial sequences give nothing.
//   cfg_* : writes glyph_count, the number of sorted table entries in use;
//           cfg_ready is always high, write only while the core is idle.
// timing
//   loads and bytes that do not complete a codepoint leave the input ready.
//   a completing byte runs a binary search through the single-port table
//   memory, one read per cycle, then moves the result to the output register
//   before the next item is taken (with no entries in use the search is skipped).
//   in_stall is high while a search runs or its result cannot yet be placed.
// reset
//   decoder state clears, glyph_count returns to 2, the table is not cleared.
//   a stalled output keeps its transaction stable until taken.
module utf8_glyph_index_lookup_core
  import ugil_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  logic [8:0] glyph_count_r;
  logic       in_fire;
  logic       busy;
  dec_res_t   dec_res;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_count_r <= GC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      glyph_count_r <= cfg_data;
    end
  end

  // input handshake, one item at a time
  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;

  ugil_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_fire && (in_data.opcode == OP_TEXT)),
    .text_byte (in_data.text_byte),
    .res       (dec_res)
  );

  ugil_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_srch (
    .clk         (clk),
    .rst_n       (rst_n),
    .glyph_count (glyph_count_r),
    .ld_en       (in_fire && (in_data.opcode == OP_LOAD)),
    .ld_idx      (in_data.entry_index),
    .ld_cp       (in_data.entry_codepoint),
    .start       (dec_res.done),
    .start_cp    (dec_res.cp),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[sim/glyph_lookup_tb_pkg.sv]
// scoreboard for the utf-8 glyph index lookup core: decoder and search predictor
// holds its own copy of the codepoint table, decoder state and glyph_count
// depends on ugil_pkg
package glyph_lookup_tb_pkg;
  import ugil_pkg::*;

  localparam int TABLE_SLOTS = 256;

  class glyph_lookup_scoreboard;
    logic [31:0] glyph_table [TABLE_SLOTS];
    logic [31:0] pend_value;
    logic [2:0]  pend_count;
    logic [8:0]  glyph_count;
    out_item_t   expected_glyphs [$];
    int          errors;

    function new();
      pend_value  = '0;
      pend_count  = '0;
      glyph_count = GC_RESET;
      errors      = 0;
      foreach (glyph_table[i]) glyph_table[i] = '0;
    endfunction

    function void set_glyph_count(logic [8:0] value);
      glyph_count = value;
    endfunction

    function int pending();
      return expected_glyphs.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // binary search over the active entries, gives up when the probe at slot 0 is above cp
    function bit find_glyph(input logic [31:0] cp, output logic [7:0] idx);
      int n;
      int lo;
      int hi;
      int mid;
      n   = (glyph_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(glyph_count);
      idx = '0;
      if (n == 0) return 1'b0;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (glyph_table[mid] < cp) begin
          lo = mid + 1;
        end else if (glyph_table[mid] == cp) begin
          idx = mid[7:0];
          return 1'b1;
        end else begin
          if (mid == 0) return 1'b0;
          hi = mid - 1;
        end
      end
      return 1'b0;
    endfunction

    // predict the effect of one accepted input transaction
    function void note_input(in_item_t item);
      logic [7:0]  b;
      logic [31:0] cp;
      logic [7:0]  idx;
      out_item_t   res;
      int          ones;
      if (item.opcode == OP_LOAD) begin
        glyph_table[item.entry_index] = item.entry_codepoint;
        return;
      end
      b = item.text_byte;
      if (pend_count == 0) begin
        // lead byte: above one, the count of leading ones is the sequence length
        ones = 0;
        while (ones < 8 && b[7 - ones]) ones++;
        cp = (ones < 8) ? {24'h0, b & (8'hFF >> ones)} : '0;
        if (ones > 1) begin
          pend_value = cp;
          pend_count = 3'(ones - 1);
          return;
        end
      end else begin
        // continuation: any byte, low six bits appended, value wraps
        pend_value = {pend_value[25:0], b[5:0] & CONT_MASK[5:0]};
        pend_count = pend_count - 3'd1;
        if (pend_count != 0) return;
        cp         = pend_value;
        pend_value = '0;
      end
      res.found         = find_glyph(cp, idx);
      res.glyph_index   = idx;
      res.codepoint_out = cp;
      expected_glyphs.push_back(res);
    endfunction

    // compare one accepted result transaction with the oldest prediction
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_glyphs.size() == 0) begin
        report($sformatf("unexpected result cp=%h idx=%0d found=%0b",
                         got.codepoint_out, got.glyph_index, got.found));
        return;
      end
      want = expected_glyphs.pop_front();
      if (got.codepoint_out !== want.codepoint_out)
        report($sformatf("codepoint_out %h, want %h", got.codepoint_out,
                         want.codepoint_out));
      if (got.found !== want.found)
        report($sformatf("found %b, want %b (cp %h)", got.found, want.found,
                         want.codepoint_out));
      if (got.glyph_index !== want.glyph_index)
        report($sformatf("glyph_index %0d, want %0d (cp %h)", got.glyph_index,
                         want.glyph_index, want.codepoint_out));
    endtask
  endclass

endpackage

[sim/tb_utf8_glyph_index_lookup_core.sv]
// top-level testbench of utf8_glyph_index_lookup_core: table loads, utf-8 text, lookups
// drives random and directed transactions with stalls, checks via the scoreboard
// depends on ugil_pkg, glyph_lookup_tb_pkg and the core rtl
module tb_utf8_glyph_index_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ugil_pkg::*;
  import glyph_lookup_tb_pkg::*;

  localparam int SETTLE      = 16;
  localparam int STUCK_LIMIT = 4000;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  in_item_t   in_data    = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data   = '0;

  glyph_lookup_scoreboard sb;
  logic [31:0] slot_values [TABLE_SLOTS];
  logic [8:0]  active_count = GC_RESET;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          stuck_cycles = 0;

  utf8_glyph_index_lookup_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitors, receiver stall and progress counter
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99, 0) < rx_stall_pct);
  end

  // watchdog on lost progress
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic in_item_t make_load(int slot, logic [31:0] value);
    in_item_t item;
    item.opcode          = OP_LOAD;
    item.entry_index     = 8'(slot);
    item.entry_codepoint = value;
    item.text_byte       = 8'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_text(logic [7:0] b);
    in_item_t item;
    item.opcode          = OP_TEXT;
    item.entry_index     = 8'($urandom);
    item.entry_codepoint = $urandom;
    item.text_byte       = b;
    return item;
  endfunction

  // shortest multi-byte sequence length able to carry the codepoint
  function automatic int min_len(logic [31:0] cp);
    if (cp < 32'h800) return 2;
    if (cp < 32'h10000) return 3;
    if (cp < 32'h200000) return 4;
    if (cp < 32'h4000000) return 5;
    if (cp < 32'h80000000) return 6;
    return 7;
  endfunction

  // one input transaction, with random sender gaps
  task automatic send_item(input in_item_t item);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_glyph_count(input logic [8:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_glyph_count(value);
    active_count = value;
    cfg_valid <= 1'b0;
  endtask

  // encode cp as a sequence of the given length; bits past 32 are random and wrap away
  task automatic send_encoded(input logic [31:0] cp, input int len, inout int sent);
    logic [63:0] wide_cp;
    logic [7:0]  b;
    int          k;
    wide_cp = {$urandom, cp};
    if (len == 0) begin
      send_item(make_text({1'b0, cp[6:0]}));
      sent++;
    end else if (len == 1) begin
      send_item(make_text(LEAD_BIT | {2'b00, cp[5:0]}));
      sent++;
    end else begin
      b = ~(8'hFF >> len) | (8'(wide_cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
      send_item(make_text(b));
      sent++;
      for (k = len - 2; k >= 0; k--) begin
        b = {2'($urandom), 6'(wide_cp >> (6 * k))};
        send_item(make_text(b));
        sent++;
      end
    end
  endtask

  task automatic send_codepoint(input logic [31:0] cp, inout int sent);
    int r;
    int len;
    r = $urandom_range(3, 0);
    if (cp < 128 && r == 0) len = 0;
    else if (cp < 64 && r == 1) len = 1;
    else len = $urandom_range(8, min_len(cp));
    send_encoded(cp, len, sent);
  endtask

  // rewrite all slots with a nondecreasing sequence
  task automatic fill_table(input bit wide);
    logic [32:0] acc;
    int          s;
    acc = wide ? 33'd0 : 33'($urandom_range(8, 1));
    for (s = 0; s < TABLE_SLOTS; s++) begin
      if (s != 0) acc = acc + (wide ? $urandom_range(1 << 24, 0) : $urandom_range(3, 0));
      if (acc > 33'hFFFFFFFF || (wide && s == TABLE_SLOTS - 1)) acc = 33'hFFFFFFFF;
      slot_values[s] = acc[31:0];
      send_item(make_load(s, acc[31:0]));
    end
  endtask

  // mostly well-formed sequences, some sorted-preserving loads and loose bytes
  task automatic run_random(input int n_items);
    int          sent;
    int          pick;
    int          n_eff;
    int          slot;
    logic [31:0] cp;
    logic [31:0] lo_v;
    logic [31:0] hi_v;
    sent = 0;
    while (sent < n_items) begin
      pick  = $urandom_range(99, 0);
      n_eff = (active_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(active_count);
      slot  = (n_eff == 0) ? $urandom_range(TABLE_SLOTS - 1, 0) : $urandom_range(n_eff - 1, 0);
      if (pick < 48) begin
        send_codepoint(slot_values[slot], sent);
      end else if (pick < 75) begin
        case ($urandom_range(3, 0))
          0: cp = slot_values[slot] + 32'd1;
          1: cp = slot_values[slot] - 32'd1;
          2: cp = $urandom;
          default: cp = $urandom_range(255, 0);
        endcase
        send_codepoint(cp, sent);
      end else if (pick < 90) begin
        slot = $urandom_range(TABLE_SLOTS - 1, 0);
        lo_v = (slot == 0) ? 32'h0 : slot_values[slot - 1];
        hi_v = (slot == TABLE_SLOTS - 1) ? 32'hFFFFFFFF : slot_values[slot + 1];
        cp   = $urandom_range(hi_v, lo_v);
        slot_values[slot] = cp;
        send_item(make_load(slot, cp));
        sent++;
      end else begin
        send_item(make_text(8'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    int k;
    int dummy;
    sb = new();
    dummy = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ascii extremes, stray continuations, longest leads, overlong zero
    fill_table(1'b0);
    send_item(make_text(8'h00));
    send_item(make_text(8'h7F));
    send_item(make_text(8'h80));
    send_item(make_text(8'hBF));
    for (k = 0; k < 8; k++) send_item(make_text(8'hFF));
    send_item(make_text(8'hC0));
    send_item(make_text(8'h80));
    send_item(make_text(8'hFE));
    for (k = 0; k < 6; k++) send_item(make_text(8'h00));
    send_encoded(slot_values[0], 0, dummy);
    send_encoded(slot_values[1], 2, dummy);

    // random phases across glyph_count settings and idle patterns
    write_glyph_count(9'd256);
    run_random(150);
    tx_idle_pct = 76;
    run_random(60);
    drain();
    run_random(50);
    tx_idle_pct  = 0;
    rx_stall_pct = 76;
    write_glyph_count(9'd1);
    run_random(60);
    tx_idle_pct  = 33;
    rx_stall_pct = 33;
    write_glyph_count(9'd0);
    run_random(40);
    fill_table(1'b1);
    write_glyph_count(9'd511);
    run_random(100);
    tx_idle_pct  = 0;
    rx_stall_pct = 76;
    write_glyph_count(9'd257);
    run_random(70);
    tx_idle_pct  = 76;
    rx_stall_pct = 0;
    write_glyph_count(9'($urandom_range(255, 3)));
    run_random(70);
    tx_idle_pct = 0;
    write_glyph_count(GC_RESET);
    run_random(60);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ugil_pkg.sv
hw/rtl/ugil_decoder.sv
hw/rtl/ugil_search.sv
hw/rtl/utf8_glyph_index_lookup_core.sv
sim/glyph_lookup_tb_pkg.sv
sim/tb_utf8_glyph_index_lookup_core.sv
